### rtl/core/asl_pkg.sv
// asl_pkg: shared types, register indexes and the control program of the
// asymmetric slew limiter. No dependencies.
package asl_pkg;

   localparam int CfgWidth      = 16;
   localparam int CsrIndexWidth = 2;
   localparam int DtWidth       = 16;
   localparam int ProdWidth     = 32;
   localparam int DenWidth      = 36;
   localparam int AddrWidth     = 4;

   // microseconds per second, applied to full_throttle_speed
   localparam logic [19:0] DEN_SCALE = 20'd1000000;

   localparam logic [CsrIndexWidth-1:0] REG_ACCEL_LIMIT = 2'd0;
   localparam logic [CsrIndexWidth-1:0] REG_DECEL_LIMIT = 2'd1;
   localparam logic [CsrIndexWidth-1:0] REG_FULL_SPEED  = 2'd2;

   typedef struct packed {
      logic [CfgWidth-1:0] accel_limit;
      logic [CfgWidth-1:0] decel_limit;
      logic [CfgWidth-1:0] full_throttle_speed;
   } cfg_type;

   typedef enum logic [3:0] {
      OP_LOAD   = 4'd0,
      OP_SEL    = 4'd1,
      OP_MUL    = 4'd2,
      OP_INIT   = 4'd3,
      OP_DIV    = 4'd4,
      OP_MOVE   = 4'd5,
      OP_SNAP   = 4'd6,
      OP_BYPASS = 4'd7,
      OP_EMIT   = 4'd8
   } op_type;

   typedef enum logic [2:0] {
      C_NEVER    = 3'd0,
      C_ALWAYS   = 3'd1,
      C_NO_REQ   = 3'd2,
      C_BYPASS   = 3'd3,
      C_SAT      = 3'd4,
      C_CNT_NZ   = 3'd5,
      C_OUT_BUSY = 3'd6
   } cond_type;

   typedef struct packed {
      op_type                op;
      cond_type              cond;
      logic [AddrWidth-1:0]  target;
   } ctrl_word_type;

   typedef struct packed {
      logic req_valid;
      logic bypass;
      logic sat;
      logic cnt_nz;
      logic out_busy;
   } status_type;

   localparam logic [AddrWidth-1:0] ADDR_WAIT   = 4'd0;
   localparam logic [AddrWidth-1:0] ADDR_SEL    = 4'd1;
   localparam logic [AddrWidth-1:0] ADDR_MUL    = 4'd2;
   localparam logic [AddrWidth-1:0] ADDR_INIT   = 4'd3;
   localparam logic [AddrWidth-1:0] ADDR_DIV    = 4'd4;
   localparam logic [AddrWidth-1:0] ADDR_MOVE   = 4'd5;
   localparam logic [AddrWidth-1:0] ADDR_SNAP   = 4'd6;
   localparam logic [AddrWidth-1:0] ADDR_BYPASS = 4'd7;
   localparam logic [AddrWidth-1:0] ADDR_EMIT   = 4'd8;
   localparam logic [AddrWidth-1:0] ADDR_LAST   = ADDR_EMIT;

   // control store: a taken jump goes to target, otherwise the next step,
   // wrapping from the last step back to the wait step
   function automatic ctrl_word_type rom_word(input logic [AddrWidth-1:0] addr);
      ctrl_word_type w;
      case (addr)
         ADDR_WAIT:   w = '{OP_LOAD,   C_NO_REQ,   ADDR_WAIT};
         ADDR_SEL:    w = '{OP_SEL,    C_NEVER,    ADDR_WAIT};
         ADDR_MUL:    w = '{OP_MUL,    C_BYPASS,   ADDR_BYPASS};
         ADDR_INIT:   w = '{OP_INIT,   C_SAT,      ADDR_MOVE};
         ADDR_DIV:    w = '{OP_DIV,    C_CNT_NZ,   ADDR_DIV};
         ADDR_MOVE:   w = '{OP_MOVE,   C_NEVER,    ADDR_WAIT};
         ADDR_SNAP:   w = '{OP_SNAP,   C_ALWAYS,   ADDR_EMIT};
         ADDR_BYPASS: w = '{OP_BYPASS, C_NEVER,    ADDR_WAIT};
         ADDR_EMIT:   w = '{OP_EMIT,   C_OUT_BUSY, ADDR_EMIT};
         default:     w = '{OP_LOAD,   C_ALWAYS,   ADDR_WAIT};
      endcase
      return w;
   endfunction

endpackage

### rtl/core/asl_sequencer.sv
// asl_sequencer: step counter and control store of the slew limiter.
// Depends on asl_pkg for the control word, status and program.
module asl_sequencer (
   input  logic                   clock,
   input  logic                   reset,
   input  asl_pkg::status_type    status,
   output asl_pkg::ctrl_word_type ctrl
);

   logic [asl_pkg::AddrWidth-1:0] step_ff;
   logic [asl_pkg::AddrWidth-1:0] step_in;
   logic                          taken;

   assign ctrl = asl_pkg::rom_word(step_ff);

   always_comb begin
      case (ctrl.cond)
         asl_pkg::C_NEVER:    taken = 1'b0;
         asl_pkg::C_ALWAYS:   taken = 1'b1;
         asl_pkg::C_NO_REQ:   taken = !status.req_valid;
         asl_pkg::C_BYPASS:   taken = status.bypass;
         asl_pkg::C_SAT:      taken = status.sat;
         asl_pkg::C_CNT_NZ:   taken = status.cnt_nz;
         asl_pkg::C_OUT_BUSY: taken = status.out_busy;
         default:             taken = 1'b1;
      endcase
   end

   always_comb begin
      if (taken) begin
         step_in = ctrl.target;
      end else if (step_ff == asl_pkg::ADDR_LAST) begin
         step_in = asl_pkg::ADDR_WAIT;
      end else begin
         step_in = step_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= asl_pkg::ADDR_WAIT;
      end else begin
         step_ff <= step_in;
      end
   end

   // the divide loop only ever leaves toward the move step
   assert property (@(posedge clock) disable iff (reset)
      (step_ff == asl_pkg::ADDR_DIV && !status.cnt_nz) |=> step_ff == asl_pkg::ADDR_MOVE)
      else $error("divide loop exit went astray");

endmodule

### rtl/core/asl_datapath.sv
// asl_datapath: operand registers, multipliers, restoring divider, move and
// snap logic and the result register. Driven by asl_sequencer; uses asl_pkg.
module asl_datapath #(
   parameter int VALUE_WIDTH = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  asl_pkg::ctrl_word_type       ctrl,
   input  asl_pkg::cfg_type             cfg,
   input  logic                         req_fire,
   input  logic                         req_valid,
   input  logic signed [VALUE_WIDTH-1:0] in_target,
   input  logic signed [VALUE_WIDTH-1:0] in_measured,
   input  logic [asl_pkg::DtWidth-1:0]  in_dt,
   input  logic                         rsp_ready,
   output logic                         rsp_valid,
   output logic [VALUE_WIDTH-1:0]       rsp_data,
   output asl_pkg::status_type          status
);

   localparam int CntWidth = $clog2(VALUE_WIDTH);
   localparam int W1 = VALUE_WIDTH + 1;
   localparam int W2 = VALUE_WIDTH + 2;
   localparam int DW = asl_pkg::DenWidth;
   localparam int PW = asl_pkg::ProdWidth;

   logic signed [VALUE_WIDTH-1:0]     target_ff, measured_ff, slewed_ff, moved_ff;
   logic [asl_pkg::DtWidth-1:0]       dt_ff;
   logic [asl_pkg::CfgWidth-1:0]      limit_ff;
   logic [asl_pkg::ProdWidth-1:0]     prod_ff;
   logic [DW-1:0]                     den_ff, rem_ff;
   logic [VALUE_WIDTH-1:0]            quo_ff;
   logic [CntWidth-1:0]               cnt_ff;
   logic [1:0]                        nb_ff;
   logic                              sat_ff;
   logic                              rsp_valid_ff;
   logic [VALUE_WIDTH-1:0]            rsp_data_ff;

   logic [VALUE_WIDTH-1:0]            mag_t, mag_m, step_size;
   logic [DW:0]                       trial, trial_sub;
   logic                              sat_now, out_write;
   logic signed [W2-1:0]              t_x, v_x, s_x, d_x, mv_x;
   logic signed [W1-1:0]              dm, dt_meas;
   logic [W1-1:0]                     abs_dm, abs_tm;

   // magnitudes fit in the value width, the most negative value included
   assign mag_t = target_ff[VALUE_WIDTH-1]   ? -target_ff   : target_ff;
   assign mag_m = measured_ff[VALUE_WIDTH-1] ? -measured_ff : measured_ff;

   // quotient reaches 2^VALUE_WIDTH exactly when prod >= 4*den
   assign sat_now = {6'd0, prod_ff} >= {den_ff, 2'b00};

   assign trial     = {rem_ff, nb_ff[1]};
   assign trial_sub = trial - {1'b0, den_ff};

   assign step_size = sat_ff ? {VALUE_WIDTH{1'b1}} : quo_ff;
   assign t_x = W2'(target_ff);
   assign v_x = W2'(slewed_ff);
   assign s_x = $signed({2'b00, step_size});
   assign d_x = t_x - v_x;

   always_comb begin
      if (d_x > s_x) begin
         mv_x = v_x + s_x;
      end else if (d_x < -s_x) begin
         mv_x = v_x - s_x;
      end else begin
         mv_x = t_x;
      end
   end

   assign dm      = W1'(moved_ff) - W1'(measured_ff);
   assign dt_meas = W1'(target_ff) - W1'(measured_ff);
   assign abs_dm  = dm[W1-1]      ? -dm      : dm;
   assign abs_tm  = dt_meas[W1-1] ? -dt_meas : dt_meas;

   assign out_write = (ctrl.op == asl_pkg::OP_EMIT) && (!rsp_valid_ff || rsp_ready);

   assign status.req_valid = req_valid;
   assign status.bypass    = (limit_ff == '0) || (cfg.full_throttle_speed == '0);
   assign status.sat       = sat_now;
   assign status.cnt_nz    = cnt_ff != '0;
   assign status.out_busy  = rsp_valid_ff && !rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      case (ctrl.op)
         asl_pkg::OP_LOAD: begin
            if (req_fire) begin
               target_ff   <= in_target;
               measured_ff <= in_measured;
               dt_ff       <= in_dt;
            end
         end
         asl_pkg::OP_SEL: begin
            limit_ff <= (mag_t > mag_m) ? cfg.accel_limit : cfg.decel_limit;
         end
         asl_pkg::OP_MUL: begin
            prod_ff <= PW'(limit_ff) * PW'(dt_ff);
            den_ff  <= DW'(cfg.full_throttle_speed) * DW'(asl_pkg::DEN_SCALE);
         end
         asl_pkg::OP_INIT: begin
            rem_ff <= DW'(prod_ff[asl_pkg::ProdWidth-1:2]);
            nb_ff  <= prod_ff[1:0];
            quo_ff <= '0;
            cnt_ff <= CntWidth'(VALUE_WIDTH - 1);
            sat_ff <= sat_now;
         end
         asl_pkg::OP_DIV: begin
            if (!trial_sub[DW]) begin
               rem_ff <= trial_sub[DW-1:0];
               quo_ff <= {quo_ff[VALUE_WIDTH-2:0], 1'b1};
            end else begin
               rem_ff <= trial[DW-1:0];
               quo_ff <= {quo_ff[VALUE_WIDTH-2:0], 1'b0};
            end
            nb_ff  <= {nb_ff[0], 1'b0};
            cnt_ff <= cnt_ff - 1'b1;
         end
         asl_pkg::OP_MOVE: begin
            // lies between the old value and the target, so no clamp needed
            moved_ff <= mv_x[VALUE_WIDTH-1:0];
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slewed_ff <= '0;
      end else if (ctrl.op == asl_pkg::OP_SNAP) begin
         slewed_ff <= (abs_dm > abs_tm) ? target_ff : moved_ff;
      end else if (ctrl.op == asl_pkg::OP_BYPASS) begin
         slewed_ff <= target_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_write) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_write) begin
         rsp_data_ff <= slewed_ff;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      (ctrl.op == asl_pkg::OP_DIV) |-> (rem_ff < den_ff))
      else $error("partial remainder not below divisor");

   assert property (@(posedge clock) disable iff (reset)
      (ctrl.op == asl_pkg::OP_SNAP) |->
         ((moved_ff >= slewed_ff && moved_ff <= target_ff) ||
          (moved_ff <= slewed_ff && moved_ff >= target_ff)))
      else $error("moved value outside old value and target");

   assert property (@(posedge clock) disable iff (reset)
      out_write |=> (rsp_valid_ff && rsp_data_ff == $past(slewed_ff)))
      else $error("result register not loaded from stored value");

endmodule

### rtl/core/asymmetric_slew_limiter.sv
// asymmetric_slew_limiter: top level with the configuration registers,
// sequencer and datapath. Depends on asl_pkg, asl_sequencer, asl_datapath.
//
//  channel  | direction | payload (low bit up)
//  req_     | in        | target_throttle, measured_throttle, step_time_us
//  rsp_     | out       | limited_throttle
//  csr_     | in        | accel_limit, decel_limit, full_throttle_speed by index
//
// an item passes the select, multiply, init, divide, move, snap and output steps
// when the step is divided out, the divide loop giving one quotient bit per cycle;
// a saturating step skips the divide loop and a disabled limiter goes to bypass
// synchronous reset clears the stored value, configuration registers, step and result valid
// the next item is taken while a result waits; a stalled result holds the
// program at its output step
module asymmetric_slew_limiter #(
   parameter int VALUE_WIDTH = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // target_throttle, measured_throttle, step_time_us, zero fill
   input  logic [((2 * VALUE_WIDTH + asl_pkg::DtWidth + 7) / 8) * 8 - 1:0] req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // limited_throttle, zero fill
   output logic [((VALUE_WIDTH + 7) / 8) * 8 - 1:0] rsp_tdata,
   input  logic                                csr_we,
   input  logic [asl_pkg::CsrIndexWidth-1:0]   csr_index,
   input  logic [asl_pkg::CfgWidth-1:0]        csr_wdata
);

   localparam int OutWidth = ((VALUE_WIDTH + 7) / 8) * 8;

   asl_pkg::cfg_type        cfg_ff;
   asl_pkg::ctrl_word_type  ctrl;
   asl_pkg::status_type     status;
   logic                    req_fire;
   logic [VALUE_WIDTH-1:0]  rsp_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            asl_pkg::REG_ACCEL_LIMIT: cfg_ff.accel_limit         <= csr_wdata;
            asl_pkg::REG_DECEL_LIMIT: cfg_ff.decel_limit         <= csr_wdata;
            asl_pkg::REG_FULL_SPEED:  cfg_ff.full_throttle_speed <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign req_tready = (ctrl.op == asl_pkg::OP_LOAD);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tdata  = OutWidth'(rsp_data);

   asl_sequencer u_sequencer (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   asl_datapath #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (ctrl),
      .cfg         (cfg_ff),
      .req_fire    (req_fire),
      .req_valid   (req_tvalid),
      .in_target   (req_tdata[VALUE_WIDTH-1:0]),
      .in_measured (req_tdata[2*VALUE_WIDTH-1:VALUE_WIDTH]),
      .in_dt       (req_tdata[2*VALUE_WIDTH+asl_pkg::DtWidth-1:2*VALUE_WIDTH]),
      .rsp_ready   (rsp_tready),
      .rsp_valid   (rsp_tvalid),
      .rsp_data    (rsp_data),
      .status      (status)
   );

   // one item at a time: a transfer is never followed by another next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_tready)
      else $error("input taken twice in a row");

endmodule
